FILE: rtl/core/variable_record_ring_keyed_completion_assert.svh
// Assertion macros for the record ring block
`ifndef VARIABLE_RECORD_RING_KEYED_COMPLETION_ASSERT_SVH
`define VARIABLE_RECORD_RING_KEYED_COMPLETION_ASSERT_SVH
`ifndef SYNTHESIS
`define VRR_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define VRR_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define VRR_ASSERT_IMPL(label, clk, rst_n, a, c)
`define VRR_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/core/vrr_pkg.sv
// Package for the record ring: types, codes and defaults
`default_nettype none
package vrr_pkg;
  localparam int unsigned RingBytesDef   = 65536;
  localparam int unsigned HeaderBytesDef = 16;
  localparam logic [16:0] MinFreeRst     = 17'd8192;
  localparam logic [15:0] ContigRst      = 16'd8;
  localparam logic [11:0] CountCap       = 12'd4095;

  localparam logic [1:0] ReqBatch  = 2'd0;
  localparam logic [1:0] ReqWord   = 2'd1;
  localparam logic [1:0] ReqLookup = 2'd2;

  localparam logic [2:0] StBatchOk  = 3'd0;
  localparam logic [2:0] StBatchRef = 3'd1;
  localparam logic [2:0] StInserted = 3'd2;
  localparam logic [2:0] StDropped  = 3'd3;
  localparam logic [2:0] StFound    = 3'd4;
  localparam logic [2:0] StNotFound = 3'd5;

  localparam logic [31:0] HdrWritten = 32'd1;
  localparam logic [31:0] HdrDone    = 32'd2;

  localparam logic RegMinFree = 1'b0;
  localparam logic RegContig  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_WFIN, S_LK_POS, S_LK_HDR, S_LK_KEY, S_LK_CHK,
    S_RC_POS, S_RC_HDR, S_RC_CHK, S_OUT
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/core/variable_record_ring_keyed_completion.sv
// Record ring block: variable-length records, keyed completion, reclaim.
// Usage:
//  Input channel in_* carries batch starts, payload words and key lookups;
//  an item is taken when in_valid is high and in_stall is low. Result
//  channel out_* gives status, inserted_count and free_bytes; it is taken
//  when out_valid is high and out_stall is low. Payload words and batch
//  starts produce at most one result, raised by S_OUT (a record's last
//  word first writes its header in S_WFIN). A lookup walks the records
//  from the consumer, two memory reads per record through the single
//  memory port (S_LK_POS to S_LK_CHK; a skipped tail gap takes S_LK_POS
//  only), then, on a match, reclaims completed records via S_RC_POS,
//  S_RC_HDR and S_RC_CHK. One item is handled at a time; the block is
//  not ready while an item is at work or its result is still held.
//  A stalled result holds its register; the next item waits until it
//  leaves. Reset empties the ring, closes any batch and restores the
//  registers; the ring memory needs no clearing.
//  Configuration is an APB-style port, 32-bit data, pready always high.
`default_nettype none
`include "variable_record_ring_keyed_completion_assert.svh"
module variable_record_ring_keyed_completion
  import vrr_pkg::*;
#(
  parameter int unsigned RING_BYTES   = RingBytesDef,
  parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic        in_first_word,
  input  wire logic [15:0] in_record_bytes,
  input  wire logic [63:0] in_data_word,
  input  wire logic [63:0] in_lookup_key,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [11:0]      out_inserted_count,
  output logic [16:0]      out_free_bytes,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int unsigned RingWords = RING_BYTES / 8;
  localparam int unsigned AW        = $clog2(RingWords);
  localparam int unsigned BW        = $clog2(RING_BYTES);
  localparam int unsigned IW        = BW + 1;
  localparam int unsigned HdrSpanI  = ((HEADER_BYTES + 7) / 8) * 8;
  localparam int unsigned HdrWordsI = HdrSpanI / 8;
  localparam logic [IW-1:0] RingB   = IW'(RING_BYTES);
  localparam logic [IW-1:0] HdrSpan = IW'(HdrSpanI);
  localparam logic [AW-1:0] HdrW    = AW'(HdrWordsI);

  // Ring memory: one port, registered read
  logic [63:0]   mem [RingWords];
  logic          mwe;
  logic [AW-1:0] maddr;
  logic [63:0]   mwdata, mrdata_r;
  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwdata;
    mrdata_r <= mem[maddr];
  end

  // State registers
  state_t        state_r, state_nxt;
  logic [IW-1:0] prod_r, prod_nxt, cons_r, cons_nxt, dist_r, dist_nxt;
  logic          stopped_r, stopped_nxt, acc_r, acc_nxt;
  logic [13:0]   left_r, left_nxt;
  logic [AW-1:0] wpos_r, wpos_nxt;
  logic [11:0]   total_r, total_nxt;
  logic [16:0]   minfree_r;
  logic [15:0]   contig_r;
  logic [63:0]   key_r, key_nxt, hdr_r, hdr_nxt;
  logic [2:0]    st_r, st_nxt;
  logic          ov_r, ov_nxt;
  logic [2:0]    ost_r;
  logic [11:0]   ocnt_r;
  logic [16:0]   ofree_r;

  // Configuration port
  assign cfg_pready = 1'b1;
  always_comb begin
    case (cfg_paddr[2])
      RegMinFree: cfg_prdata = {15'd0, minfree_r};
      RegContig:  cfg_prdata = {16'd0, contig_r};
      default:    cfg_prdata = '0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minfree_r <= MinFreeRst;
      contig_r  <= ContigRst;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      case (cfg_paddr[2])
        RegMinFree: minfree_r <= cfg_pwdata[16:0];
        RegContig:  contig_r  <= cfg_pwdata[15:0];
        default:    ;
      endcase
    end
  end

  // Shared occupancy and position arithmetic
  logic [IW-1:0] used_raw, used, free_b, lim, cpos, crem, ppos, prem;
  always_comb begin
    used_raw = prod_r - cons_r;
    used     = (used_raw > RingB) ? RingB : used_raw;
    free_b   = RingB - used;
    lim      = HdrSpan + IW'(contig_r);
    ppos     = {1'b0, prod_r[BW-1:0]};
    prem     = RingB - ppos;
    cpos     = {1'b0, cons_r[BW-1:0] + dist_r[BW-1:0]};
    crem     = RingB - cpos;
  end

  wire in_acc  = in_valid && !in_stall;
  wire out_acc = out_valid && !out_stall;
  assign in_stall = (state_r != S_IDLE) || ov_r;

  // First-word arithmetic; the space need keeps one extra bit
  logic [13:0]   nw;
  logic [IW-1:0] actual, gap;
  logic [IW:0]   need;
  always_comb begin
    nw = 14'((17'(in_record_bytes) + 17'd7) >> 3);
    if (nw == 14'd0) nw = 14'd1;
    actual = HdrSpan + IW'({nw, 3'b000});
    gap    = (prem < lim) ? prem : '0;
    need   = {1'b0, gap} + {1'b0, actual} + (IW+1)'(8);
  end

  // Header write size on record finish
  logic [AW-1:0] hp, pw;
  logic [IW-1:0] rsize;
  always_comb begin
    hp    = prod_r[BW-1:3];
    pw    = wpos_r - hp - HdrW;
    rsize = HdrSpan + IW'({pw, 3'b000});
  end

  wire [31:0] hsize = hdr_r[31:0];

  // Sequencer
  always_comb begin
    state_nxt = state_r; prod_nxt = prod_r; cons_nxt = cons_r; dist_nxt = dist_r;
    stopped_nxt = stopped_r; acc_nxt = acc_r; left_nxt = left_r; wpos_nxt = wpos_r;
    total_nxt = total_r; key_nxt = key_r; hdr_nxt = hdr_r; st_nxt = st_r;
    ov_nxt = ov_r; mwe = 1'b0; maddr = wpos_r; mwdata = in_data_word;
    if (out_acc) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req_type)
            ReqBatch: begin
              left_nxt = '0; acc_nxt = 1'b0; total_nxt = '0;
              stopped_nxt = (IW'(minfree_r) > free_b);
              st_nxt = stopped_nxt ? StBatchRef : StBatchOk;
              state_nxt = S_OUT;
            end
            ReqWord: begin
              if (in_first_word) begin
                acc_nxt = 1'b0;
                if (!stopped_r) begin
                  if ({1'b0, free_b} >= need) begin
                    prod_nxt = prod_r + gap;
                    acc_nxt = 1'b1;
                  end else stopped_nxt = 1'b1;
                end
                if (acc_nxt) begin
                  maddr = prod_nxt[BW-1:3] + HdrW;
                  mwe = 1'b1;
                  wpos_nxt = maddr + AW'(1);
                end
                left_nxt = nw - 14'd1;
                if (left_nxt == 14'd0) state_nxt = S_WFIN;
              end else if (left_r != 14'd0) begin
                if (acc_r) begin
                  mwe = 1'b1;
                  wpos_nxt = wpos_r + AW'(1);
                end
                left_nxt = left_r - 14'd1;
                if (left_nxt == 14'd0) state_nxt = S_WFIN;
              end
            end
            ReqLookup: begin
              key_nxt = in_lookup_key; dist_nxt = '0; state_nxt = S_LK_POS;
            end
            default: ;
          endcase
        end
      end
      S_WFIN: begin
        st_nxt = StDropped;
        if (acc_r) begin
          maddr = hp; mwe = 1'b1;
          mwdata = {HdrWritten, 32'(rsize)};
          prod_nxt = prod_r + rsize;
          if (total_r < CountCap) total_nxt = total_r + 12'd1;
          st_nxt = StInserted;
        end
        acc_nxt = 1'b0;
        state_nxt = S_OUT;
      end
      S_LK_POS: begin
        if (dist_r >= used) begin
          st_nxt = StNotFound; state_nxt = S_OUT;
        end else if (crem < lim) begin
          dist_nxt = dist_r + crem;
        end else begin
          maddr = cpos[BW-1:3]; state_nxt = S_LK_HDR;
        end
      end
      S_LK_HDR: begin
        hdr_nxt = mrdata_r;
        maddr = cpos[BW-1:3] + HdrW;
        state_nxt = S_LK_KEY;
      end
      S_LK_KEY: begin
        // Hold the key address so the read data stays valid
        maddr = cpos[BW-1:3] + HdrW;
        state_nxt = S_LK_CHK;
      end
      S_LK_CHK: begin
        if (hdr_r[63:32] == HdrWritten && mrdata_r == key_r) begin
          maddr = cpos[BW-1:3]; mwe = 1'b1;
          mwdata = {HdrDone, hsize};
          st_nxt = StFound; state_nxt = S_RC_POS;
        end else if (hsize == 32'd0) begin
          st_nxt = StNotFound; state_nxt = S_OUT;
        end else begin
          dist_nxt = dist_r + hsize[IW-1:0];
          if (hsize[31:IW] != '0) dist_nxt = used;
          state_nxt = S_LK_POS;
        end
      end
      S_RC_POS: begin
        dist_nxt = '0;
        if (used == '0) state_nxt = S_OUT;
        else if (RingB - {1'b0, cons_r[BW-1:0]} < lim) begin
          if (RingB - {1'b0, cons_r[BW-1:0]} >= used) cons_nxt = prod_r;
          else cons_nxt = cons_r + (RingB - {1'b0, cons_r[BW-1:0]});
        end else begin
          maddr = cons_r[BW-1:3]; state_nxt = S_RC_HDR;
        end
      end
      S_RC_HDR: begin
        // Hold the header address so the read data stays valid
        maddr = cons_r[BW-1:3];
        state_nxt = S_RC_CHK;
      end
      S_RC_CHK: begin
        if (mrdata_r[63:32] != HdrDone || mrdata_r[31:0] == 32'd0) state_nxt = S_OUT;
        else begin
          if (mrdata_r[31:IW] != '0 || mrdata_r[IW-1:0] >= used) cons_nxt = prod_r;
          else cons_nxt = cons_r + mrdata_r[IW-1:0];
          state_nxt = S_RC_POS;
        end
      end
      S_OUT: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; prod_r <= '0; cons_r <= '0; dist_r <= '0;
      stopped_r <= 1'b1; acc_r <= 1'b0; left_r <= '0; wpos_r <= '0;
      total_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; prod_r <= prod_nxt; cons_r <= cons_nxt; dist_r <= dist_nxt;
      stopped_r <= stopped_nxt; acc_r <= acc_nxt; left_r <= left_nxt; wpos_r <= wpos_nxt;
      total_r <= total_nxt; ov_r <= ov_nxt;
    end
  end

  // Result payload, loaded as the result is raised
  always_ff @(posedge clk) begin
    key_r <= key_nxt; hdr_r <= hdr_nxt; st_r <= st_nxt;
    if (state_r == S_OUT) begin
      ost_r <= st_r; ocnt_r <= total_r; ofree_r <= free_b[16:0];
    end
  end

  assign out_valid          = ov_r;
  assign out_status         = ost_r;
  assign out_inserted_count = ocnt_r;
  assign out_free_bytes     = ofree_r;

  `VRR_ASSERT_IMPL(a_busy_stall, clk, rst_n, state_r != S_IDLE, in_stall)
  `VRR_ASSERT_IMPL(a_used_bound, clk, rst_n, 1'b1, used_raw <= RingB)
  `VRR_ASSERT_NEXT(a_out_after, clk, rst_n, state_r == S_OUT, out_valid)
  `VRR_ASSERT_NEXT(a_cons_move, clk, rst_n, state_r == S_IDLE && !in_acc, $stable(cons_r))
endmodule
`default_nettype wire
